[src/i2cwrs_pkg.sv]
// Package for the I2C master write/read sequencer.
// Holds the item kind, phase, flag and status codes and the result beat type.
// No dependencies.
package i2cwrs_pkg;

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_EVENT   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SB      = 3'd1;
  localparam logic [2:0] PH_ADDR    = 3'd2;
  localparam logic [2:0] PH_TXE     = 3'd3;
  localparam logic [2:0] PH_RX_SB   = 3'd4;
  localparam logic [2:0] PH_RX_ADDR = 3'd5;
  localparam logic [2:0] PH_RXNE    = 3'd6;

  localparam int unsigned FL_SB   = 0;
  localparam int unsigned FL_ADDR = 1;
  localparam int unsigned FL_TXE  = 2;
  localparam int unsigned FL_RXNE = 3;
  localparam int unsigned FL_BTF  = 4;
  localparam int unsigned FL_TRA  = 5;
  localparam int unsigned FL_ARLO = 7;
  localparam int unsigned FL_AF   = 8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_NO_DEVICE = 3'd2;
  localparam logic [2:0] ST_REG_NACK  = 3'd3;
  localparam logic [2:0] ST_DATA_NACK = 3'd4;
  localparam logic [2:0] ST_ARB_LOST  = 3'd5;

  typedef struct packed {
    logic       gen_start;
    logic       gen_stop;
    logic       ack_enable;
    logic       addr_valid;
    logic [7:0] addr_byte;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic [2:0] status;
    logic       buf_irq_enable;
  } res_t;

endpackage

[src/i2c_master_write_read_sequencer_top.sv]
// Top level of the I2C master write/read sequencer.
// Depends on i2cwrs_pkg for codes and the result beat type.
//
// Usage: the input channel carries one beat per driver call: a start
// request, an event interrupt, an error interrupt or a timeout abort.
// For every accepted input beat exactly one result beat appears on the
// output channel, in order, telling the driver what to write to the
// peripheral (START, STOP, ACK level, address, data) and whether the
// transfer has finished with which status.
// Each result is registered, in the output register or in the skid register if one waits.
// Throughput: one beat per cycle while in_stall_o is low; the decode of a beat and the
// update of the transfer state complete in the cycle in which it is accepted.
// Stall: the result register is backed by one skid register, so a beat
// is still taken while a result waits; in_stall_o rises only when both
// are full and falls once the receiver takes a beat.
// Reset: the transfer state returns to idle, counts and address clear,
// and both output registers are empty.
module i2c_master_write_read_sequencer_top
  import i2cwrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [6:0] dev_addr_i,
  input  logic [7:0] tx_count_i,
  input  logic [7:0] rx_count_i,
  input  logic [8:0] event_flags_i,
  input  logic [7:0] tx_byte_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       gen_start_o,
  output logic       gen_stop_o,
  output logic       ack_enable_o,
  output logic       addr_valid_o,
  output logic [7:0] addr_byte_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_data_o,
  output logic       rx_valid_o,
  output logic [7:0] rx_data_o,
  output logic       done_res_o,
  output logic [2:0] status_o,
  output logic       buf_irq_enable_o
);

  logic [2:0] phase_q, phase_d;
  logic [6:0] addr_q, addr_d;
  logic [7:0] tx_left_q, tx_left_d;
  logic [7:0] rx_left_q, rx_left_d;
  logic       buf_en_q, buf_en_d;
  logic       ack_q, ack_d;

  res_t res_d;
  res_t out_q;
  res_t skid_q;
  logic out_valid_q;
  logic skid_valid_q;

  logic accept;
  logic out_fire;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    logic       done;
    logic       fail;
    logic [2:0] code;
    phase_d   = phase_q;
    addr_d    = addr_q;
    tx_left_d = tx_left_q;
    rx_left_d = rx_left_q;
    buf_en_d  = buf_en_q;
    ack_d     = ack_q;
    res_d     = '0;
    done      = 1'b0;
    fail      = 1'b0;
    code      = ST_OK;

    if (kind_i == KIND_START) begin
      addr_d          = dev_addr_i;
      tx_left_d       = tx_count_i;
      rx_left_d       = rx_count_i;
      ack_d           = 1'b1;
      buf_en_d        = 1'b1;
      phase_d         = PH_SB;
      res_d.gen_start = 1'b1;
    end else if (phase_q != PH_IDLE) begin
      unique case (kind_i)
        KIND_EVENT: begin
          if (event_flags_i[FL_SB]) begin
            res_d.addr_valid = 1'b1;
            if (tx_left_q != 8'd0) begin
              res_d.addr_byte = {addr_q, 1'b0};
              phase_d         = PH_ADDR;
            end else begin
              res_d.addr_byte = {addr_q, 1'b1};
              phase_d         = PH_RX_ADDR;
            end
          end else if (event_flags_i[FL_ADDR]) begin
            if (tx_left_q != 8'd0) begin
              phase_d = PH_TXE;
            end else begin
              buf_en_d = 1'b1;
              if (rx_left_q == 8'd1) begin
                ack_d          = 1'b0;
                res_d.gen_stop = 1'b1;
              end else begin
                ack_d = 1'b1;
              end
              phase_d = PH_RXNE;
            end
          end
          if (buf_en_q) begin
            if (event_flags_i[FL_TXE] && event_flags_i[FL_TRA]) begin
              if (tx_left_q != 8'd0) begin
                res_d.tx_valid = 1'b1;
                res_d.tx_data  = tx_byte_i;
                tx_left_d      = tx_left_q - 8'd1;
              end else begin
                buf_en_d = 1'b0;
              end
            end
            if (event_flags_i[FL_RXNE] && rx_left_q != 8'd0 && tx_left_d == 8'd0) begin
              res_d.rx_valid = 1'b1;
              res_d.rx_data  = rx_byte_i;
              rx_left_d      = rx_left_q - 8'd1;
              if (rx_left_d == 8'd1) begin
                ack_d          = 1'b0;
                res_d.gen_stop = 1'b1;
              end else if (rx_left_d == 8'd0) begin
                done = 1'b1;
                code = ST_OK;
              end
            end
          end
          if (!done && event_flags_i[FL_BTF] && event_flags_i[FL_TRA]) begin
            if (rx_left_d != 8'd0) begin
              res_d.gen_start = 1'b1;
              phase_d         = PH_RX_SB;
              buf_en_d        = 1'b0;
            end else begin
              res_d.gen_stop = 1'b1;
              done           = 1'b1;
              code           = ST_OK;
            end
          end
        end
        KIND_ERROR: begin
          if (event_flags_i[FL_ARLO]) begin
            code = ST_ARB_LOST;
            fail = 1'b1;
          end
          if (event_flags_i[FL_AF]) begin
            if (phase_q == PH_ADDR) begin
              code = ST_NO_DEVICE;
            end else if (phase_q == PH_RX_ADDR) begin
              code = ST_REG_NACK;
            end else begin
              code = ST_DATA_NACK;
            end
            res_d.gen_stop = 1'b1;
            fail           = 1'b1;
          end
          done = fail;
        end
        KIND_TIMEOUT: begin
          done = 1'b1;
          code = ST_TIMEOUT;
        end
        default: begin
          done = 1'b0;
        end
      endcase
      if (done) begin
        phase_d        = PH_IDLE;
        buf_en_d       = 1'b0;
        res_d.done_res = 1'b1;
        res_d.status   = code;
      end
    end

    res_d.ack_enable     = ack_d;
    res_d.buf_irq_enable = buf_en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      addr_q    <= '0;
      tx_left_q <= '0;
      rx_left_q <= '0;
      buf_en_q  <= 1'b0;
      ack_q     <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      addr_q    <= addr_d;
      tx_left_q <= tx_left_d;
      rx_left_q <= rx_left_d;
      buf_en_q  <= buf_en_d;
      ack_q     <= ack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign in_stall_o       = skid_valid_q;
  assign out_valid_o      = out_valid_q;
  assign gen_start_o      = out_q.gen_start;
  assign gen_stop_o       = out_q.gen_stop;
  assign ack_enable_o     = out_q.ack_enable;
  assign addr_valid_o     = out_q.addr_valid;
  assign addr_byte_o      = out_q.addr_byte;
  assign tx_valid_o       = out_q.tx_valid;
  assign tx_data_o        = out_q.tx_data;
  assign rx_valid_o       = out_q.rx_valid;
  assign rx_data_o        = out_q.rx_data;
  assign done_res_o       = out_q.done_res;
  assign status_o         = out_q.status;
  assign buf_irq_enable_o = out_q.buf_irq_enable;

endmodule

[src/i2cwrs_checker.sv]
// Port checker for the I2C master write/read sequencer, bound to the top level.
// Depends on i2cwrs_pkg for the status codes.
module i2cwrs_port_assert
  import i2cwrs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       gen_start_o,
  input logic       addr_valid_o,
  input logic [7:0] addr_byte_o,
  input logic       tx_valid_o,
  input logic [7:0] tx_data_o,
  input logic       done_res_o,
  input logic [2:0] status_o,
  input logic       buf_irq_enable_o
);

  // A status code other than success is only reported on a completing beat.
  a_status_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == ST_OK)
    else $error("status without completion");

  // A finished transfer releases the buffer events and never restarts in the same beat.
  a_done_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !buf_irq_enable_o && !gen_start_o)
    else $error("completion with buffer events or start");

  // Address and transmit bytes are zero unless they are to be sent.
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (addr_valid_o || addr_byte_o == 8'd0) && (tx_valid_o || tx_data_o == 8'd0))
    else $error("stale address or data byte");

  // A stalled result beat stays on the port.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(done_res_o))
    else $error("stalled result beat changed");

endmodule

bind i2c_master_write_read_sequencer_top i2cwrs_port_assert u_i2cwrs_port_assert (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .gen_start_o      (gen_start_o),
  .addr_valid_o     (addr_valid_o),
  .addr_byte_o      (addr_byte_o),
  .tx_valid_o       (tx_valid_o),
  .tx_data_o        (tx_data_o),
  .done_res_o       (done_res_o),
  .status_o         (status_o),
  .buf_irq_enable_o (buf_irq_enable_o)
);

[tb/i2cwrs_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the I2C master write/read sequencer: tracks the transfer state from
// the accepted input beats and compares every result beat with its prediction.
// Depends on i2cwrs_pkg for item kinds, phases, flag positions, status codes and res_t.
module i2cwrs_checker
  import i2cwrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] kind_i,
  input  logic [6:0] dev_addr_i,
  input  logic [7:0] tx_count_i,
  input  logic [7:0] rx_count_i,
  input  logic [8:0] event_flags_i,
  input  logic [7:0] tx_byte_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       gen_start_i,
  input  logic       gen_stop_i,
  input  logic       ack_enable_i,
  input  logic       addr_valid_i,
  input  logic [7:0] addr_byte_i,
  input  logic       tx_valid_i,
  input  logic [7:0] tx_data_i,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_data_i,
  input  logic       done_res_i,
  input  logic [2:0] status_i,
  input  logic       buf_irq_enable_i,
  output int         err_count_o,
  output int         pending_o
);

  res_t        driver_cmds[$];
  logic [2:0]  seq_phase;
  logic [6:0]  addr_q;
  logic [7:0]  writes_left;
  logic [7:0]  reads_left;
  logic [2:0]  last_code;
  logic        buf_en;
  logic        ack_lvl;
  int unsigned beat_no;

  function automatic void end_transfer(input logic [2:0] code, inout res_t r);
    last_code = code;
    seq_phase = PH_IDLE;
    buf_en = 1'b0;
    r.done_res = 1'b1;
    r.status = code;
  endfunction

  function automatic res_t next_driver_cmd(input logic [1:0] kind, input logic [6:0] addr,
                                           input logic [7:0] txc, input logic [7:0] rxc,
                                           input logic [8:0] flags, input logic [7:0] txb,
                                           input logic [7:0] rxb);
    res_t       r;
    logic       buf_was;
    logic       fail;
    logic       ended;
    logic [2:0] code;
    r = '0;
    buf_was = buf_en;
    fail = 1'b0;
    ended = 1'b0;
    code = ST_OK;
    if (kind == KIND_START) begin
      addr_q = addr;
      writes_left = txc;
      reads_left = rxc;
      last_code = ST_TIMEOUT;
      ack_lvl = 1'b1;
      buf_en = 1'b1;
      seq_phase = PH_SB;
      r.gen_start = 1'b1;
    end else if (seq_phase != PH_IDLE) begin
      case (kind)
        KIND_EVENT: begin
          if (flags[FL_SB]) begin
            r.addr_valid = 1'b1;
            if (writes_left != 8'd0) begin
              r.addr_byte = {addr_q, 1'b0};
              seq_phase = PH_ADDR;
            end else begin
              r.addr_byte = {addr_q, 1'b1};
              seq_phase = PH_RX_ADDR;
            end
          end else if (flags[FL_ADDR]) begin
            if (writes_left != 8'd0) begin
              seq_phase = PH_TXE;
            end else begin
              buf_en = 1'b1;
              if (reads_left == 8'd1) begin
                ack_lvl = 1'b0;
                r.gen_stop = 1'b1;
              end else begin
                ack_lvl = 1'b1;
              end
              seq_phase = PH_RXNE;
            end
          end
          if (buf_was && flags[FL_TXE] && flags[FL_TRA]) begin
            if (writes_left != 8'd0) begin
              r.tx_valid = 1'b1;
              r.tx_data = txb;
              writes_left = writes_left - 8'd1;
            end else begin
              buf_en = 1'b0;
            end
          end
          if (buf_was && flags[FL_RXNE] && reads_left != 8'd0 && writes_left == 8'd0) begin
            r.rx_valid = 1'b1;
            r.rx_data = rxb;
            reads_left = reads_left - 8'd1;
            if (reads_left == 8'd1) begin
              ack_lvl = 1'b0;
              r.gen_stop = 1'b1;
            end else if (reads_left == 8'd0) begin
              end_transfer(ST_OK, r);
              ended = 1'b1;
            end
          end
          if (!ended && flags[FL_BTF] && flags[FL_TRA]) begin
            if (reads_left != 8'd0) begin
              r.gen_start = 1'b1;
              seq_phase = PH_RX_SB;
              buf_en = 1'b0;
            end else begin
              r.gen_stop = 1'b1;
              end_transfer(ST_OK, r);
            end
          end
        end
        KIND_ERROR: begin
          if (flags[FL_ARLO]) begin
            code = ST_ARB_LOST;
            fail = 1'b1;
          end
          if (flags[FL_AF]) begin
            if (seq_phase == PH_ADDR) code = ST_NO_DEVICE;
            else if (seq_phase == PH_RX_ADDR) code = ST_REG_NACK;
            else code = ST_DATA_NACK;
            r.gen_stop = 1'b1;
            fail = 1'b1;
          end
          if (fail) end_transfer(code, r);
        end
        default: begin
          end_transfer(ST_TIMEOUT, r);
        end
      endcase
    end
    r.ack_enable = ack_lvl;
    r.buf_irq_enable = buf_en;
    return r;
  endfunction

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got,
                           inout bit bad);
    if (want != got) begin
      if (err_count_o < 10) begin
        $display("result %0d: %s expected %0h got %0h", beat_no, name, want, got);
      end
      bad = 1'b1;
    end
  endtask

  task automatic check_beat();
    res_t want;
    bit   bad;
    bad = 1'b0;
    if (driver_cmds.size() == 0) begin
      if (err_count_o < 10) $display("result %0d arrived with nothing expected", beat_no);
      err_count_o++;
    end else begin
      want = driver_cmds.pop_front();
      cmp_field("gen_start", want.gen_start, gen_start_i, bad);
      cmp_field("gen_stop", want.gen_stop, gen_stop_i, bad);
      cmp_field("ack_enable", want.ack_enable, ack_enable_i, bad);
      cmp_field("addr_valid", want.addr_valid, addr_valid_i, bad);
      cmp_field("addr_byte", want.addr_byte, addr_byte_i, bad);
      cmp_field("tx_valid", want.tx_valid, tx_valid_i, bad);
      cmp_field("tx_data", want.tx_data, tx_data_i, bad);
      cmp_field("rx_valid", want.rx_valid, rx_valid_i, bad);
      cmp_field("rx_data", want.rx_data, rx_data_i, bad);
      cmp_field("done_res", want.done_res, done_res_i, bad);
      cmp_field("status", want.status, status_i, bad);
      cmp_field("buf_irq_enable", want.buf_irq_enable, buf_irq_enable_i, bad);
      if (bad) err_count_o++;
    end
    beat_no++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      driver_cmds.delete();
      seq_phase = PH_IDLE;
      addr_q = '0;
      writes_left = '0;
      reads_left = '0;
      last_code = ST_OK;
      buf_en = 1'b0;
      ack_lvl = 1'b0;
      beat_no = 0;
      err_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_beat();
      if (in_valid_i && !in_stall_i) begin
        driver_cmds.push_back(next_driver_cmd(kind_i, dev_addr_i, tx_count_i, rx_count_i,
                                              event_flags_i, tx_byte_i, rx_byte_i));
      end
      pending_o = driver_cmds.size();
    end
  end

endmodule

[tb/tb_i2c_master_write_read_sequencer_top.sv]
`timescale 1ns / 1ps
// Testbench top for the I2C master write/read sequencer: directed transfers, then random
// well-formed transfers mixed with noise, with random gaps and output stalls.
// Depends on i2cwrs_pkg, the sequencer RTL and i2cwrs_checker.
module tb_i2c_master_write_read_sequencer_top;
  import i2cwrs_pkg::*;

  localparam int unsigned FL_BERR_BIT = 6;
  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 1000000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] kind;
  logic [6:0] dev_addr;
  logic [7:0] tx_count;
  logic [7:0] rx_count;
  logic [8:0] event_flags;
  logic [7:0] tx_byte;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       gen_start;
  logic       gen_stop;
  logic       ack_enable;
  logic       addr_valid;
  logic [7:0] addr_byte;
  logic       tx_valid;
  logic [7:0] tx_data;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic       done_res;
  logic [2:0] status;
  logic       buf_irq_enable;
  int         err_count;
  int         pending;
  int         items_sent = 0;
  int         cycle_count = 0;
  bit         burst = 1'b0;
  bit         noisy = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  i2c_master_write_read_sequencer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .dev_addr_i      (dev_addr),
    .tx_count_i      (tx_count),
    .rx_count_i      (rx_count),
    .event_flags_i   (event_flags),
    .tx_byte_i       (tx_byte),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .gen_start_o     (gen_start),
    .gen_stop_o      (gen_stop),
    .ack_enable_o    (ack_enable),
    .addr_valid_o    (addr_valid),
    .addr_byte_o     (addr_byte),
    .tx_valid_o      (tx_valid),
    .tx_data_o       (tx_data),
    .rx_valid_o      (rx_valid),
    .rx_data_o       (rx_data),
    .done_res_o      (done_res),
    .status_o        (status),
    .buf_irq_enable_o(buf_irq_enable)
  );

  i2cwrs_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .kind_i          (kind),
    .dev_addr_i      (dev_addr),
    .tx_count_i      (tx_count),
    .rx_count_i      (rx_count),
    .event_flags_i   (event_flags),
    .tx_byte_i       (tx_byte),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .gen_start_i     (gen_start),
    .gen_stop_i      (gen_stop),
    .ack_enable_i    (ack_enable),
    .addr_valid_i    (addr_valid),
    .addr_byte_i     (addr_byte),
    .tx_valid_i      (tx_valid),
    .tx_data_i       (tx_data),
    .rx_valid_i      (rx_valid),
    .rx_data_i       (rx_data),
    .done_res_i      (done_res),
    .status_i        (status),
    .buf_irq_enable_i(buf_irq_enable),
    .err_count_o     (err_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      repeat (hold) @(negedge clk_i);
      out_stall <= 1'b1;
      hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      repeat (hold) @(negedge clk_i);
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'd0;
    if (r < 80) return 8'($urandom_range(1, 4));
    if (r < 98) return 8'($urandom_range(5, 20));
    return 8'($urandom_range(200, 255));
  endfunction

  function automatic logic [8:0] flag_bit(input int unsigned b);
    return 9'b1 << b;
  endfunction

  task automatic send_beat(input logic [1:0] k, input logic [6:0] a, input logic [7:0] tc,
                           input logic [7:0] rc, input logic [8:0] fl, input logic [7:0] tb,
                           input logic [7:0] rb);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind <= k;
    dev_addr <= a;
    tx_count <= tc;
    rx_count <= rc;
    event_flags <= fl;
    tx_byte <= tb;
    rx_byte <= rb;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_noise();
    send_beat(2'($urandom), 7'($urandom), 8'($urandom), 8'($urandom), 9'($urandom),
              8'($urandom), 8'($urandom));
  endtask

  task automatic start_beat(input logic [6:0] a, input logic [7:0] tc, input logic [7:0] rc);
    send_beat(KIND_START, a, tc, rc, 9'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic event_beat(input logic [8:0] fl);
    if (noisy && $urandom_range(0, 59) == 0) send_noise();
    if (noisy && $urandom_range(0, 3) == 0) fl = fl | flag_bit(FL_BERR_BIT);
    send_beat(KIND_EVENT, 7'($urandom), 8'($urandom), 8'($urandom), fl, 8'($urandom),
              8'($urandom));
  endtask

  task automatic error_beat(input logic [8:0] fl);
    send_beat(KIND_ERROR, 7'($urandom), 8'($urandom), 8'($urandom), fl, 8'($urandom),
              8'($urandom));
  endtask

  task automatic timeout_beat();
    send_beat(KIND_TIMEOUT, 7'($urandom), 8'($urandom), 8'($urandom), 9'($urandom),
              8'($urandom), 8'($urandom));
  endtask

  task automatic run_transfer(input logic [7:0] tc, input logic [7:0] rc);
    start_beat(7'($urandom), tc, rc);
    event_beat(flag_bit(FL_SB));
    event_beat(flag_bit(FL_ADDR));
    if (tc != 8'd0) begin
      repeat (tc) event_beat(flag_bit(FL_TXE) | flag_bit(FL_TRA));
      event_beat(flag_bit(FL_BTF) | flag_bit(FL_TRA) |
                 (($urandom_range(0, 1) == 1) ? flag_bit(FL_TXE) : 9'b0));
      if (rc != 8'd0) begin
        event_beat(flag_bit(FL_SB));
        event_beat(flag_bit(FL_ADDR));
      end
    end
    if (rc != 8'd0) begin
      repeat (rc) begin
        event_beat(flag_bit(FL_RXNE) | (($urandom_range(0, 1) == 1) ? flag_bit(FL_TRA) : 9'b0));
      end
    end else if (tc == 8'd0) begin
      timeout_beat();
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int sel;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    kind = KIND_TIMEOUT;
    dev_addr = '0;
    tx_count = '0;
    rx_count = '0;
    event_flags = '0;
    tx_byte = '0;
    rx_byte = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // An event while idle changes nothing.
    event_beat(9'h1FF);
    // Single-byte write ending in STOP.
    start_beat(7'd127, 8'd1, 8'd0);
    event_beat(flag_bit(FL_SB));
    event_beat(flag_bit(FL_ADDR));
    event_beat(flag_bit(FL_TXE) | flag_bit(FL_TRA));
    event_beat(flag_bit(FL_BTF) | flag_bit(FL_TRA));
    // Write then repeated-start single-byte read.
    start_beat(7'd0, 8'd1, 8'd1);
    event_beat(flag_bit(FL_SB));
    event_beat(flag_bit(FL_ADDR));
    event_beat(flag_bit(FL_TXE) | flag_bit(FL_TRA));
    event_beat(flag_bit(FL_BTF) | flag_bit(FL_TRA));
    event_beat(flag_bit(FL_SB));
    event_beat(flag_bit(FL_ADDR));
    event_beat(flag_bit(FL_RXNE));
    // Empty transfer with a lone bus error, ended by a timeout.
    start_beat(7'h2A, 8'd0, 8'd0);
    event_beat(flag_bit(FL_SB));
    event_beat(flag_bit(FL_BERR_BIT));
    timeout_beat();
    // Address not acknowledged.
    start_beat(7'h55, 8'd2, 8'd0);
    event_beat(flag_bit(FL_SB));
    error_beat(flag_bit(FL_AF));
    // Both errors on a read address: the acknowledge failure wins.
    start_beat(7'h11, 8'd0, 8'd3);
    event_beat(flag_bit(FL_SB));
    error_beat(flag_bit(FL_ARLO) | flag_bit(FL_AF) | flag_bit(FL_BERR_BIT));
    // A start abandons the busy transfer, then arbitration is lost.
    start_beat(7'h66, 8'd3, 8'd3);
    start_beat(7'h19, 8'd2, 8'd2);
    error_beat(flag_bit(FL_ARLO));
    // Acknowledge failure before the address went out.
    start_beat(7'h33, 8'd4, 8'd0);
    error_beat(flag_bit(FL_AF));
    wait_drained();

    noisy = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      burst = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        run_transfer(pick_count(), pick_count());
      end else if (sel < 92) begin
        send_noise();
      end else if (sel < 98) begin
        start_beat(7'($urandom), pick_count(), pick_count());
        repeat ($urandom_range(0, 3)) send_noise();
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
